// File: hw/rtl/bol_pkg.sv
// Shared types and constants of the bounded ordered list.
`timescale 1ns / 1ps
package bol_pkg;

	localparam int MODE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	// Operation codes carried in the input item.
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD_FRONT    = 3'd0,
		MODE_ADD_BACK     = 3'd1,
		MODE_REMOVE_FIRST = 3'd2,
		MODE_REMOVE_LAST  = 3'd3,
		MODE_REMOVE_AT    = 3'd4
	} mode_t;

	// Status codes carried in the result item.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// What the slot row does for one item.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_TAKE
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
	} cmd_t;

endpackage

// File: hw/rtl/bounded_ordered_list.sv
// Top level of the bounded ordered list: input stage, list logic and result stage.
`timescale 1ns / 1ps
// The block keeps an ordered list of up to CAPACITY signed 32-bit values and
// performs one operation per input item: add at the front, add at the back,
// remove the first, remove the last, or remove the element at a zero-based
// position, after which the later elements close up. Every item yields
// exactly one result item with the added or removed value (zero on an
// error), a status (ok, empty, full, position out of range) and the element
// count after the operation. Unused mode codes leave the list unchanged and
// report ok with a zero value. An item is captured in an input register;
// when the result register is free or is being emptied, the decoder and
// the slot row, in which every slot picks its next value from itself, a
// neighbor or the new value in parallel, settle the operation and load the
// result register. One item is accepted in every cycle while the output
// side keeps taking results; the parallel update of the slot row sets that
// rate. When the output stalls, the input register holds one more item
// before s_tready drops. No clearing pass follows reset: only occupied
// slots are ever read, and each of them has been written.
module bounded_ordered_list import bol_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // mode[2:0], value[34:3], position[38:35], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // result_value[31:0], status[33:32], count[38:34], zero pad
);

	localparam int OCC_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int WIDE_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

	// Input stage.
	logic               valid_s1;
	logic [MODE_W-1:0]  mode_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]   position_s1;

	// Result stage.
	logic               valid_s2;
	logic [VALUE_W-1:0] result_value_s2;
	status_t            status_s2;
	logic [COUNT_W-1:0] count_s2;

	logic               in_fire;
	logic               adv;
	cmd_t               cmd;
	logic [IDX_W-1:0]   idx;
	logic [OCC_W-1:0]   occ;
	logic [OCC_W-1:0]   occ_next;
	logic [VALUE_W-1:0] rd_data;
	logic [VALUE_W-1:0] result_value;

	// The operation in the input stage completes whenever the result stage
	// is free or is being emptied in this cycle.
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1     <= s_tdata[2:0];
			value_s1    <= s_tdata[34:3];
			position_s1 <= s_tdata[38:35];
		end
	end

	bol_ctrl #(
		.CAPACITY (CAPACITY),
		.OCC_W    (OCC_W),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.mode     (mode_s1),
		.position (position_s1),
		.cmd      (cmd),
		.idx      (idx),
		.occ      (occ),
		.occ_next (occ_next)
	);

	bol_slots #(
		.CAPACITY (CAPACITY),
		.OCC_W    (OCC_W),
		.IDX_W    (IDX_W)
	) u_slots (
		.clk     (clk),
		.en      (adv),
		.cmd     (cmd),
		.idx     (idx),
		.occ     (occ),
		.value   (value_s1),
		.rd_data (rd_data)
	);

	// Adds echo the new value, removals return the slot that leaves the list,
	// and errors or unused codes return zero.
	always_comb begin
		case (cmd.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: result_value = value_s1;
			OP_TAKE:                     result_value = rd_data;
			default:                     result_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_value_s2 <= result_value;
			status_s2       <= cmd.status;
			count_s2        <= COUNT_W'(WIDE_W'(occ_next));
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, count_s2, status_s2, result_value_s2};

	// The count never grows past the capacity.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= OCC_W'(CAPACITY))
		else $error("occupancy exceeds capacity");

	// A successful add grows the list by exactly one element.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK)
		|=> occ == $past(occ) + 1'b1)
		else $error("add did not grow the list by one");

	// An operation that fails or does nothing leaves the count alone.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd.op == OP_NONE |=> occ == $past(occ))
		else $error("count changed on a failed operation");

	// The input side stalls only when both stages are full and the output waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a full pipeline");

endmodule

// File: hw/rtl/bol_ctrl.sv
// Operation decoder and occupancy counter of the bounded ordered list.
`timescale 1ns / 1ps
module bol_ctrl import bol_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int OCC_W    = $clog2(CAPACITY + 1),
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [MODE_W-1:0]   mode,
	input  logic [POS_W-1:0]    position,
	output cmd_t                cmd,
	output logic [IDX_W-1:0]    idx,
	output logic [OCC_W-1:0]    occ,
	output logic [OCC_W-1:0]    occ_next
);

	localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

	logic [OCC_W-1:0] occupancy_q;
	logic [OCC_W-1:0] last_idx;
	logic [CMP_W-1:0] pos_wide;
	logic [CMP_W-1:0] occ_wide;
	logic             is_full;
	logic             is_empty;

	assign is_full  = (occupancy_q == OCC_W'(CAPACITY));
	assign is_empty = (occupancy_q == '0);
	assign last_idx = occupancy_q - 1'b1;
	assign pos_wide = CMP_W'(position);
	assign occ_wide = CMP_W'(occupancy_q);

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.status = ST_OK;
		idx        = '0;
		unique case (mode)
			MODE_ADD_FRONT, MODE_ADD_BACK: begin
				if (is_full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.op = (mode == MODE_ADD_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				end
			end
			MODE_REMOVE_FIRST: begin
				if (is_empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.op = OP_TAKE;
				end
			end
			MODE_REMOVE_LAST: begin
				if (is_empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.op = OP_TAKE;
					idx    = last_idx[IDX_W-1:0];
				end
			end
			MODE_REMOVE_AT: begin
				if (is_empty) begin
					cmd.status = ST_EMPTY;
				end else if (pos_wide >= occ_wide) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.op = OP_TAKE;
					idx    = pos_wide[IDX_W-1:0];
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: occ_next = occupancy_q + 1'b1;
			OP_TAKE:                     occ_next = occupancy_q - 1'b1;
			default:                     occ_next = occupancy_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (en) begin
			occupancy_q <= occ_next;
		end
	end

	assign occ = occupancy_q;

endmodule

// File: hw/rtl/bol_slots.sv
// Row of value slots that shifts in parallel for front inserts and removals.
`timescale 1ns / 1ps
module bol_slots import bol_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int OCC_W    = $clog2(CAPACITY + 1),
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                en,
	input  cmd_t                cmd,
	input  logic [IDX_W-1:0]    idx,
	input  logic [OCC_W-1:0]    occ,
	input  logic [VALUE_W-1:0]  value,
	output logic [VALUE_W-1:0]  rd_data
);

	logic [VALUE_W-1:0] slots_q [CAPACITY];
	logic [VALUE_W-1:0] slots_d [CAPACITY];

	// Each slot picks its next value from itself, its neighbors or the new value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_val;
		logic [VALUE_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = value;
		end else begin : g_inner_l
			assign left_val = slots_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = slots_q[i];
		end else begin : g_inner_r
			assign right_val = slots_q[i+1];
		end

		always_comb begin
			slots_d[i] = slots_q[i];
			case (cmd.op)
				OP_PUSH_FRONT: slots_d[i] = left_val;
				OP_PUSH_BACK: begin
					if (occ == OCC_W'(i)) begin
						slots_d[i] = value;
					end
				end
				OP_TAKE: begin
					if (IDX_W'(i) >= idx) begin
						slots_d[i] = right_val;
					end
				end
				default: slots_d[i] = slots_q[i];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slots_q <= slots_d;
		end
	end

	assign rd_data = slots_q[idx];

endmodule
